[hw/rtl/bfd_pkg.sv]
// Shared types, register codes, frame constants and checksum helper for the echo generator.
`default_nettype none

package bfd_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_DEST_MAC      = 4'd0,
    REG_SOURCE_MAC    = 4'd1,
    REG_ADDR_HIGH     = 4'd2,
    REG_ADDR_LOW      = 4'd3,
    REG_MY_DISC       = 4'd4,
    REG_ADV_INTERVALS = 4'd5,
    REG_ECHO_INTERVAL = 4'd6,
    REG_CONTROL       = 4'd7
  } reg_index_t;

  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 64;
  localparam int NonceW    = 32;

  // Default depth of the job queue between front and back
  localparam int QueueDepth = 2;

  // Control register bits
  localparam int CtrlIpv6Bit   = 8;
  localparam int CtrlEnableBit = 9;

  // Frame constants
  localparam logic [15:0] EtherTypeV4 = 16'h0800;
  localparam logic [15:0] EtherTypeV6 = 16'h86dd;
  localparam logic [7:0]  V4VerIhl    = 8'h45;
  localparam logic [7:0]  V4Tos       = 8'hc0;
  localparam logic [7:0]  V6FirstByte = 8'h6c;
  localparam logic [7:0]  HopLimit    = 8'd255;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [15:0] EchoPort    = 16'd3785;
  localparam logic [15:0] UdpLen      = 16'd32;
  localparam logic [15:0] V4TotalLen  = 16'd52;
  localparam logic [7:0]  BfdVersByte = 8'h20;
  localparam logic [7:0]  BfdFlags    = 8'hc0;
  localparam logic [7:0]  BfdLen      = 8'd24;
  localparam logic [15:0] UdpZeroSum  = 16'hffff;

  // Fixed part of the UDP sum: pseudo-header length and protocol, both ports, UDP length
  localparam logic [15:0] UdpConstSum =
    16'(int'(UdpLen) + int'(ProtoUdp) + 2 * int'(EchoPort) + int'(UdpLen));
  // Fixed part of the IPv4 header sum
  localparam logic [20:0] V4HdrConstSum =
    21'(int'({V4VerIhl, V4Tos}) + int'(V4TotalLen) + int'({HopLimit, ProtoUdp}));

  // Frame layout in 64-bit words
  localparam int FrameWords = 11;
  localparam int FrameBits  = FrameWords * 64;
  localparam logic [3:0] LastWordV4 = 4'd8;
  localparam logic [3:0] LastWordV6 = 4'd10;
  localparam logic [3:0] TailBytesV4 = 4'd2;
  localparam logic [3:0] TailBytesV6 = 4'd6;
  localparam logic [3:0] FullBytes   = 4'd8;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [63:0] local_addr_high;
    logic [63:0] local_addr_low;
    logic [31:0] my_discriminator;
    logic [63:0] advertised_intervals;
    logic [31:0] echo_interval_us;
    logic [9:0]  control;
  } cfg_t;

  typedef struct packed {
    logic [63:0] now_us;
    logic        session_up;
    logic        dest_mac_valid;
  } in_item_t;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic [31:0] frame_nonce;
  } out_item_t;

  // Fold a sum of 16-bit words into a ones-complement checksum
  function automatic logic [15:0] csum_fold(input logic [20:0] s);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = 17'(s[15:0]) + 17'(s[20:16]);
    s2 = s1[15:0] + 16'(s1[16]);
    return ~s2;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bfd_fifo.sv]
// Short job queue carrying echo nonces from the front to the back.
`default_nettype none

module bfd_fifo #(
  parameter int Depth = bfd_pkg::QueueDepth
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [bfd_pkg::NonceW-1:0] push_data,
  output logic                            full,
  output logic                            pop_valid,
  input  wire logic                       pop_ready,
  output logic [bfd_pkg::NonceW-1:0]      pop_data
);

  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  logic [bfd_pkg::NonceW-1:0] mem [Depth];
  logic [PtrW-1:0]            wr_ptr;
  logic [PtrW-1:0]            rd_ptr;
  logic [CountW-1:0]          count;
  logic                       pop;

  assign full      = (count == CountW'(Depth));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rd_ptr];

  // Store pushed nonces
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Depth) && (pop_valid || !pop))
    else $error("job queue occupancy out of range");

endmodule

`default_nettype wire

[hw/rtl/bfd_front.sv]
// Front: configuration registers, tick acceptance, due-time check and nonce scheduling.
`default_nettype none

module bfd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire bfd_pkg::in_item_t             in_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bfd_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [bfd_pkg::CfgDataW-1:0]  cfg_data,
  output bfd_pkg::cfg_t                      cfg,
  output logic                               push,
  output logic [bfd_pkg::NonceW-1:0]         push_nonce,
  input  wire logic                          full
);

  logic [63:0]                next_due_time;
  logic [bfd_pkg::NonceW-1:0] nonce_counter;
  logic                       accept;
  logic                       due;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;

  // Classify the tick: send only when enabled, running, up, MAC known and due
  assign due = cfg.control[bfd_pkg::CtrlEnableBit]
            && (cfg.echo_interval_us != '0)
            && in_item.session_up
            && in_item.dest_mac_valid
            && (in_item.now_us >= next_due_time);

  assign push       = accept && due;
  assign push_nonce = nonce_counter + 1'b1;

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (bfd_pkg::reg_index_t'(cfg_index))
        bfd_pkg::REG_DEST_MAC:      cfg.dest_mac             <= cfg_data[47:0];
        bfd_pkg::REG_SOURCE_MAC:    cfg.source_mac           <= cfg_data[47:0];
        bfd_pkg::REG_ADDR_HIGH:     cfg.local_addr_high      <= cfg_data;
        bfd_pkg::REG_ADDR_LOW:      cfg.local_addr_low       <= cfg_data;
        bfd_pkg::REG_MY_DISC:       cfg.my_discriminator     <= cfg_data[31:0];
        bfd_pkg::REG_ADV_INTERVALS: cfg.advertised_intervals <= cfg_data;
        bfd_pkg::REG_ECHO_INTERVAL: cfg.echo_interval_us     <= cfg_data[31:0];
        bfd_pkg::REG_CONTROL:       cfg.control              <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Schedule the next echo and advance the nonce
  always_ff @(posedge clk) begin
    if (rst) begin
      next_due_time <= '0;
      nonce_counter <= '0;
    end else if (push) begin
      next_due_time <= in_item.now_us + 64'(cfg.echo_interval_us);
      nonce_counter <= push_nonce;
    end
  end

  a_nonce_step: assert property (@(posedge clk) disable iff (rst)
    push |=> (nonce_counter == $past(nonce_counter) + 32'd1))
    else $error("nonce did not advance by one on an echo");

endmodule

`default_nettype wire

[hw/rtl/bfd_back.sv]
// Back: checksum sequencer and frame serialiser with a registered output stage.
`default_nettype none

module bfd_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bfd_pkg::cfg_t              cfg,
  input  wire logic                       job_valid,
  output logic                            job_ready,
  input  wire logic [bfd_pkg::NonceW-1:0] job_nonce,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output bfd_pkg::out_item_t              out_item
);

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_SUM  = 4'b0010,
    CS_FOLD = 4'b0100,
    CS_DONE = 4'b1000
  } cs_state_t;

  typedef struct packed {
    logic [bfd_pkg::NonceW-1:0] nonce;
    logic [15:0]                ip_csum;
    logic [15:0]                udp_csum;
  } frame_info_t;

  localparam int NumTerms  = 28;
  localparam int TermsStep = 4;
  localparam logic [2:0] LastStep = 3'(NumTerms / TermsStep - 1);
  localparam int FrameBits_W = bfd_pkg::FrameBits;

  cs_state_t   cs_state;
  logic [2:0]  step;
  logic [20:0] acc;
  logic [20:0] ip_acc;
  frame_info_t cs_info;
  logic [15:0] udp_fold;

  logic        active;
  logic [3:0]  widx;
  frame_info_t cur;
  logic        load_ser;
  logic        advance;
  logic        is_last;

  logic               ipv6;
  logic [15:0]        addr_words [8];
  logic [15:0]        terms [NumTerms];
  logic [20:0]        step_sum;
  logic [191:0]       payload;
  logic [FrameBits_W-1:0] frame;
  logic [63:0]        words [bfd_pkg::FrameWords];

  assign ipv6 = cfg.control[bfd_pkg::CtrlIpv6Bit];

  // Gather the UDP checksum terms; source and destination addresses are equal
  always_comb begin
    if (ipv6) begin
      addr_words[0] = cfg.local_addr_high[63:48];
      addr_words[1] = cfg.local_addr_high[47:32];
      addr_words[2] = cfg.local_addr_high[31:16];
      addr_words[3] = cfg.local_addr_high[15:0];
      addr_words[4] = cfg.local_addr_low[63:48];
      addr_words[5] = cfg.local_addr_low[47:32];
    end else begin
      addr_words[0] = '0;
      addr_words[1] = '0;
      addr_words[2] = '0;
      addr_words[3] = '0;
      addr_words[4] = '0;
      addr_words[5] = '0;
    end
    addr_words[6] = cfg.local_addr_low[31:16];
    addr_words[7] = cfg.local_addr_low[15:0];
    for (int i = 0; i < 8; i++) begin
      terms[i]     = addr_words[i];
      terms[i + 8] = addr_words[i];
    end
    terms[16] = bfd_pkg::UdpConstSum;
    terms[17] = {bfd_pkg::BfdVersByte, bfd_pkg::BfdFlags};
    terms[18] = {cfg.control[7:0], bfd_pkg::BfdLen};
    terms[19] = cfg.my_discriminator[31:16];
    terms[20] = cfg.my_discriminator[15:0];
    terms[21] = cfg.advertised_intervals[63:48];
    terms[22] = cfg.advertised_intervals[47:32];
    terms[23] = cfg.advertised_intervals[31:16];
    terms[24] = cfg.advertised_intervals[15:0];
    terms[25] = cs_info.nonce[31:16];
    terms[26] = cs_info.nonce[15:0];
    terms[27] = '0;
  end

  // Add four terms per step
  always_comb begin
    logic [4:0] base;
    base     = {step, 2'b00};
    step_sum = acc;
    for (int j = 0; j < TermsStep; j++) begin
      step_sum = step_sum + 21'(terms[base + 5'(j)]);
    end
  end

  assign udp_fold  = bfd_pkg::csum_fold(acc);
  assign job_ready = (cs_state == CS_IDLE);
  assign load_ser  = (cs_state == CS_DONE) && !active;

  // Run the checksum sequence for one job, then hold the result for the serialiser
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_state <= CS_IDLE;
      step     <= '0;
    end else begin
      case (cs_state)
        CS_IDLE: begin
          if (job_valid) begin
            cs_state <= CS_SUM;
            step     <= '0;
          end
        end
        CS_SUM: begin
          if (step == LastStep) begin
            cs_state <= CS_FOLD;
          end
          step <= step + 1'b1;
        end
        CS_FOLD: cs_state <= CS_DONE;
        CS_DONE: begin
          if (load_ser) begin
            cs_state <= CS_IDLE;
          end
        end
        default: cs_state <= CS_IDLE;
      endcase
    end
  end

  // Checksum datapath
  always_ff @(posedge clk) begin
    case (cs_state)
      CS_IDLE: begin
        acc           <= '0;
        cs_info.nonce <= job_nonce;
        ip_acc        <= bfd_pkg::V4HdrConstSum
                       + 21'({cfg.local_addr_low[31:16], 1'b0})
                       + 21'({cfg.local_addr_low[15:0], 1'b0});
      end
      CS_SUM: acc <= step_sum;
      CS_FOLD: begin
        cs_info.ip_csum  <= bfd_pkg::csum_fold(ip_acc);
        cs_info.udp_csum <= (udp_fold == '0) ? bfd_pkg::UdpZeroSum : udp_fold;
      end
      default: ;
    endcase
  end

  // Build the frame image, first wire byte at the top
  assign payload = {bfd_pkg::BfdVersByte, bfd_pkg::BfdFlags, cfg.control[7:0],
                    bfd_pkg::BfdLen, cfg.my_discriminator, 32'h0,
                    cfg.advertised_intervals, cur.nonce};

  always_comb begin
    if (ipv6) begin
      frame = {cfg.dest_mac, cfg.source_mac, bfd_pkg::EtherTypeV6,
               bfd_pkg::V6FirstByte, 24'h0, bfd_pkg::UdpLen,
               bfd_pkg::ProtoUdp, bfd_pkg::HopLimit,
               cfg.local_addr_high, cfg.local_addr_low,
               cfg.local_addr_high, cfg.local_addr_low,
               bfd_pkg::EchoPort, bfd_pkg::EchoPort, bfd_pkg::UdpLen,
               cur.udp_csum, payload, 16'h0};
    end else begin
      frame = {cfg.dest_mac, cfg.source_mac, bfd_pkg::EtherTypeV4,
               bfd_pkg::V4VerIhl, bfd_pkg::V4Tos, bfd_pkg::V4TotalLen, 32'h0,
               bfd_pkg::HopLimit, bfd_pkg::ProtoUdp, cur.ip_csum,
               cfg.local_addr_low[31:0], cfg.local_addr_low[31:0],
               bfd_pkg::EchoPort, bfd_pkg::EchoPort, bfd_pkg::UdpLen,
               cur.udp_csum, payload, 176'h0};
    end
  end

  for (genvar k = 0; k < bfd_pkg::FrameWords; k++) begin : g_words
    assign words[k] = frame[FrameBits_W - 1 - 64 * k -: 64];
  end

  assign is_last = (widx == (ipv6 ? bfd_pkg::LastWordV6 : bfd_pkg::LastWordV4));
  assign advance = active && (!out_valid || out_ready);

  // Serialise the frame word by word into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_ser) begin
        active <= 1'b1;
        widx   <= '0;
      end else if (advance) begin
        if (is_last) begin
          active <= 1'b0;
        end else begin
          widx <= widx + 1'b1;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch frame info and output payload
  always_ff @(posedge clk) begin
    if (load_ser) begin
      cur <= cs_info;
    end
    if (advance) begin
      out_item.frame_word  <= words[widx];
      out_item.last_word   <= is_last;
      out_item.frame_nonce <= cur.nonce;
      out_item.valid_bytes <= !is_last ? bfd_pkg::FullBytes
                            : (ipv6 ? bfd_pkg::TailBytesV6 : bfd_pkg::TailBytesV4);
    end
  end

  a_tail_bytes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last_word) |->
      (out_item.valid_bytes == bfd_pkg::TailBytesV4
       || out_item.valid_bytes == bfd_pkg::TailBytesV6))
    else $error("last word carries a wrong byte count");
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    load_ser |=> (active && widx == '0 && cs_state == CS_IDLE))
    else $error("checksum result not handed to the serialiser");

endmodule

`default_nettype wire

[hw/rtl/bfd_echo_frame_generator_top.sv]
// Top level of the echo frame generator: front, job queue and back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | in        | in_valid / in_ready     | in_item  (now_us, flags)
//   out     | out       | out_valid / out_ready   | out_item (one frame word)
//   cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A tick is taken whenever the job queue is not full. A tick that sends an echo
// yields 9 (IPv4) or 11 (IPv6) words; the serialiser emits one word a cycle
// while the output is not stalled, with a load step between frames.
// The checksum unit adds four terms a cycle (7 steps plus load and fold) while
// the previous frame is still going out.
// Reset is synchronous and clears the configuration, schedule and control
// registers, not the data registers; cfg_ready is always high. A stalled output
// holds its word; the job queue lets ticks keep arriving until it fills.
`default_nettype none

module bfd_echo_frame_generator_top #(
  parameter int QueueDepth = bfd_pkg::QueueDepth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire bfd_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bfd_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bfd_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [bfd_pkg::CfgDataW-1:0]  cfg_data
);

  bfd_pkg::cfg_t              cfg;
  logic                       push;
  logic [bfd_pkg::NonceW-1:0] push_nonce;
  logic                       full;
  logic                       job_valid;
  logic                       job_ready;
  logic [bfd_pkg::NonceW-1:0] job_nonce;

  bfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .push       (push),
    .push_nonce (push_nonce),
    .full       (full)
  );

  bfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_nonce),
    .full      (full),
    .pop_valid (job_valid),
    .pop_ready (job_ready),
    .pop_data  (job_nonce)
  );

  bfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_nonce (job_nonce),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[verif/bfd_echo_frame_generator_tb.sv]
// Self-checking testbench for the echo frame generator: directed rows, then random ticks.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 200000;
  localparam int RandomTicks  = 168;
  localparam int PhaseTicks   = 28;

  localparam logic [3:0]  SpareRegIndex = 4'd11;
  localparam logic [9:0]  CtrlOn        = 10'h200;
  localparam logic [9:0]  CtrlV6        = 10'h100;
  localparam logic [15:0] EchoUdpPort   = 16'd3785;

  typedef enum {ROW_TICK, ROW_WRITE, ROW_ZERO_SUM} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [3:0]        index;
    logic [63:0]       data;
    bfd_pkg::in_item_t tick;
    bit                silent;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  bfd_pkg::in_item_t  in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  bfd_pkg::out_item_t out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [bfd_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [bfd_pkg::CfgDataW-1:0]  cfg_data = '0;

  // Own copy of the registers and the scheduling state
  bfd_pkg::cfg_t shadow = '0;
  logic [63:0] next_due = '0;
  logic [31:0] nonce_count = '0;

  bfd_pkg::out_item_t pending_words [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        steady = 1'b0;
  bit        hold_req = 1'b0;

  // Directed rows: every tick goes to the predictor; silent ticks must also send nothing
  row_t directed_rows [36] = '{
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{64'h0, 1'b1, 1'b1}, 1'b1},
    '{ROW_WRITE,    bfd_pkg::REG_CONTROL,       64'(CtrlOn | 10'h003),
      '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{64'h0, 1'b1, 1'b1}, 1'b1},
    '{ROW_WRITE,    bfd_pkg::REG_DEST_MAC,      64'hffff_ffff_ffff,
      '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_SOURCE_MAC,    64'h0, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ADDR_LOW,      '1, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_MY_DISC,       64'hffff_ffff, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ADV_INTERVALS, '1, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ECHO_INTERVAL, 64'h1, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{64'h0, 1'b1, 1'b1}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{64'h0, 1'b1, 1'b1}, 1'b1},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{64'h5, 1'b0, 1'b1}, 1'b1},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{64'h5, 1'b1, 1'b0}, 1'b1},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{64'h1, 1'b1, 1'b1}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ADDR_HIGH,     '1, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ECHO_INTERVAL, 64'hffff_ffff, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_CONTROL,       64'h3ff, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{'1, 1'b1, 1'b1}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{64'hffff_fffe, 1'b1, 1'b1}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0,
      '{64'h1_ffff_fffc, 1'b1, 1'b1}, 1'b1},
    '{ROW_WRITE,    bfd_pkg::REG_CONTROL,       64'h1ff, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0, '{'1, 1'b1, 1'b1}, 1'b1},
    '{ROW_WRITE,    SpareRegIndex,              '1, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_DEST_MAC,      64'h0, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_SOURCE_MAC,    64'hffff_ffff_ffff,
      '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ADDR_HIGH,     64'h0, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ADDR_LOW,      64'h0, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ADV_INTERVALS, 64'h0, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_ECHO_INTERVAL, 64'd10, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_CONTROL,       64'(CtrlOn), '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_ZERO_SUM, bfd_pkg::REG_MY_DISC,       64'h0, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0,
      '{64'h1_ffff_fffd, 1'b1, 1'b1}, 1'b0},
    '{ROW_WRITE,    bfd_pkg::REG_CONTROL,       64'(CtrlOn | CtrlV6),
      '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_ZERO_SUM, bfd_pkg::REG_MY_DISC,       64'h0, '{64'h0, 1'b0, 1'b0}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0,
      '{64'h2_0000_0010, 1'b1, 1'b1}, 1'b0},
    '{ROW_TICK,     bfd_pkg::REG_DEST_MAC,      64'h0,
      '{64'hffff_ffff_ffff_fff0, 1'b1, 1'b1}, 1'b0}
  };

  bfd_echo_frame_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Lay out the frame with both checksum fields still zero
  function automatic logic [703:0] lay_out_frame(input logic [31:0] nonce,
                                                 input logic [31:0] disc);
    logic [191:0] body;
    logic [31:0]  v4addr;
    body = {8'h20, 8'hc0, shadow.control[7:0], 8'd24, disc, 32'h0,
            shadow.advertised_intervals, nonce};
    v4addr = shadow.local_addr_low[31:0];
    if (shadow.control[bfd_pkg::CtrlIpv6Bit]) begin
      return {shadow.dest_mac, shadow.source_mac, 16'h86dd, 8'h6c, 24'h0, 16'd32,
              8'd17, 8'd255, shadow.local_addr_high, shadow.local_addr_low,
              shadow.local_addr_high, shadow.local_addr_low,
              EchoUdpPort, EchoUdpPort, 16'd32, 16'h0, body, 16'h0};
    end
    return {shadow.dest_mac, shadow.source_mac, 16'h0800, 8'h45, 8'hc0, 16'd52,
            32'h0, 8'd255, 8'd17, 16'h0, v4addr, v4addr,
            EchoUdpPort, EchoUdpPort, 16'd32, 16'h0, body, 176'h0};
  endfunction

  // Add big-endian 16-bit words starting at byte offset first
  function automatic int unsigned word_sum(input logic [703:0] f, input int first,
                                           input int count);
    int unsigned s;
    s = 0;
    for (int i = 0; i < count / 2; i++) s += f[703 - 8 * (first + 2 * i) -: 16];
    return s;
  endfunction

  function automatic logic [15:0] fold16(input int unsigned s);
    while (s >> 16) s = (s & 32'hffff) + (s >> 16);
    return s[15:0];
  endfunction

  // Folded UDP sum over pseudo-header, header and payload, before inversion
  function automatic logic [15:0] udp_sum(input logic [703:0] f, input bit v6);
    return fold16(word_sum(f, v6 ? 22 : 26, v6 ? 64 : 40) + 32'd32 + 32'd17);
  endfunction

  // Discriminator that drives the next frame's UDP checksum to zero
  function automatic logic [63:0] zero_sum_disc();
    logic [15:0] s;
    s = udp_sum(lay_out_frame(nonce_count + 32'd1, 32'h0),
                shadow.control[bfd_pkg::CtrlIpv6Bit]);
    return {48'h0, 16'hffff - s};
  endfunction

  // Advance the schedule for one tick and queue the frame words it sends
  function automatic int predict_echo(input bfd_pkg::in_item_t t);
    logic [703:0] f;
    logic [15:0]  csum;
    bfd_pkg::out_item_t w;
    bit           v6;
    int           len;
    int           nw;
    if (!shadow.control[bfd_pkg::CtrlEnableBit] || shadow.echo_interval_us == 0) return 0;
    if (!t.session_up || !t.dest_mac_valid || t.now_us < next_due) return 0;
    next_due = t.now_us + 64'(shadow.echo_interval_us);
    nonce_count = nonce_count + 32'd1;
    v6 = shadow.control[bfd_pkg::CtrlIpv6Bit];
    f = lay_out_frame(nonce_count, shadow.my_discriminator);
    if (!v6) f[703 - 8 * 24 -: 16] = ~fold16(word_sum(f, 14, 20));
    csum = ~udp_sum(f, v6);
    if (csum == 16'h0) csum = 16'hffff;
    f[703 - 8 * (v6 ? 60 : 40) -: 16] = csum;
    len = v6 ? 86 : 66;
    nw = (len + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      w.frame_word  = f[703 - 64 * k -: 64];
      w.valid_bytes = (len - 8 * k > 8) ? 4'd8 : 4'(len - 8 * k);
      w.last_word   = (k == nw - 1);
      w.frame_nonce = nonce_count;
      pending_words.push_back(w);
    end
    return nw;
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bfd_pkg::REG_DEST_MAC:      shadow.dest_mac = d[47:0];
      bfd_pkg::REG_SOURCE_MAC:    shadow.source_mac = d[47:0];
      bfd_pkg::REG_ADDR_HIGH:     shadow.local_addr_high = d;
      bfd_pkg::REG_ADDR_LOW:      shadow.local_addr_low = d;
      bfd_pkg::REG_MY_DISC:       shadow.my_discriminator = d[31:0];
      bfd_pkg::REG_ADV_INTERVALS: shadow.advertised_intervals = d;
      bfd_pkg::REG_ECHO_INTERVAL: shadow.echo_interval_us = d[31:0];
      bfd_pkg::REG_CONTROL:       shadow.control = d[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one tick, hold it until taken, then predict; returns words expected
  task automatic offer_tick(input bfd_pkg::in_item_t t, output int words);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = t;
    do @(posedge clk); while (!in_ready);
    words = predict_echo(t);
    @(negedge clk);
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic settle();
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic scramble_config();
    logic [31:0] interval;
    logic [9:0]  ctrl;
    logic [63:0] pick;
    case ($urandom_range(15))
      0: interval = 32'h0;
      1, 2: interval = $urandom;
      default: interval = $urandom_range(1, 50);
    endcase
    pick = pick_value();
    ctrl = {($urandom_range(9) != 0) ? 1'b1 : 1'b0, 1'($urandom_range(1)), pick[7:0]};
    write_reg(bfd_pkg::REG_DEST_MAC, pick_value());
    write_reg(bfd_pkg::REG_SOURCE_MAC, pick_value());
    write_reg(bfd_pkg::REG_ADDR_HIGH, pick_value());
    write_reg(bfd_pkg::REG_ADDR_LOW, pick_value());
    write_reg(bfd_pkg::REG_MY_DISC, pick_value());
    write_reg(bfd_pkg::REG_ADV_INTERVALS, pick_value());
    write_reg(bfd_pkg::REG_ECHO_INTERVAL, {$urandom, interval});
    write_reg(bfd_pkg::REG_CONTROL, {$urandom, 22'($urandom), ctrl});
    if ($urandom_range(3) == 0) write_reg(SpareRegIndex, pick_value());
  endtask

  // Mostly ticks around the due time with good flags; the rest is noise
  function automatic bfd_pkg::in_item_t make_tick();
    bfd_pkg::in_item_t t;
    if ($urandom_range(99) < 10) begin
      t.now_us         = {$urandom, $urandom};
      t.session_up     = 1'($urandom_range(1));
      t.dest_mac_valid = 1'($urandom_range(1));
      return t;
    end
    t.session_up     = $urandom_range(99) < 90;
    t.dest_mac_valid = $urandom_range(99) < 90;
    if ($urandom_range(99) < 65) t.now_us = next_due + 64'($urandom_range(0, 3));
    else t.now_us = next_due - 64'd1 - 64'($urandom_range(0, shadow.echo_interval_us));
    return t;
  endfunction

  // Receiver: random back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_ready = steady || ($urandom_range(99) >= 24);
      end
    end
  end

  // Check each frame word against the oldest expectation
  always @(posedge clk) begin
    bfd_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("frame word %h with no frame expected", out_item.frame_word);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (out_item.frame_word !== want.frame_word) begin
          $error("frame_word expected %h actual %h", want.frame_word, out_item.frame_word);
          mismatches++;
        end
        if (out_item.valid_bytes !== want.valid_bytes) begin
          $error("valid_bytes expected %0d actual %0d", want.valid_bytes,
                 out_item.valid_bytes);
          mismatches++;
        end
        if (out_item.last_word !== want.last_word) begin
          $error("last_word expected %b actual %b", want.last_word, out_item.last_word);
          mismatches++;
        end
        if (out_item.frame_nonce !== want.frame_nonce) begin
          $error("frame_nonce expected %h actual %h", want.frame_nonce,
                 out_item.frame_nonce);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int words;
    int counted;
    int phase;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_TICK: begin
          offer_tick(directed_rows[i].tick, words);
          if (directed_rows[i].silent && words != 0) begin
            $error("row %0d: tick should send nothing", i);
            mismatches++;
          end
        end
        ROW_WRITE: begin
          settle();
          write_reg(directed_rows[i].index, directed_rows[i].data);
        end
        ROW_ZERO_SUM: begin
          settle();
          write_reg(bfd_pkg::REG_MY_DISC, zero_sum_disc());
        end
        default: ;
      endcase
    end

    // Random phases: fresh settings, then a burst of ticks
    counted = 0;
    phase = 0;
    while (counted < RandomTicks) begin
      settle();
      scramble_config();
      steady = (phase == 1 || phase == 3);
      if (phase == 1) begin
        // Make sure the burst sends, so the hold-off backs up into the input
        write_reg(bfd_pkg::REG_ECHO_INTERVAL, 64'd1);
        write_reg(bfd_pkg::REG_CONTROL, 64'(shadow.control | CtrlOn));
        hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseTicks; n++) begin
        offer_tick(make_tick(), words);
        counted++;
      end
      phase++;
    end
    steady = 1'b0;

    settle();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
